@@ src/vfrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vfrp_pkg: shared types and constants for the video frame release pacer
// Payload structs for both channels, the configuration register map,
// reset values and the fixed timing thresholds.
// ----------------------------------------------------------------------------
package vfrp_pkg;

    // Query / painted-event transaction
    typedef struct packed {
        logic        mode;
        logic [7:0]  queued_count;
        logic        front_has_stamp;
        logic [31:0] front_stamp;
        logic [31:0] newest_stamp;
        logic [31:0] now_ms;
        logic [31:0] audio_clock;
        logic [31:0] painted_frame_stamp;
        logic [31:0] painted_time;
    } vfrp_in_t;

    // Result transaction
    typedef struct packed {
        logic        release_now;
        logic [31:0] video_clock;
    } vfrp_out_t;

    // Configuration register set
    typedef struct packed {
        logic        sync_enable;
        logic [15:0] min_buffer_ms;
        logic [15:0] sync_tolerance_ms;
        logic [15:0] max_interval_ms;
    } vfrp_cfg_t;

    // Decision unit status back to the top level
    typedef struct packed {
        logic release_now;
        logic audio_update;
    } vfrp_dec_t;

    // Transaction kinds
    localparam logic MODE_QUERY   = 1'b0;
    localparam logic MODE_PAINTED = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BUFFER_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TOLERANCE_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL_MS   = 2'd3;

    localparam logic        RST_SYNC_ENABLE       = 1'b0;
    localparam logic [15:0] RST_MIN_BUFFER_MS     = 16'd100;
    localparam logic [15:0] RST_SYNC_TOLERANCE_MS = 16'd200;
    localparam logic [15:0] RST_MAX_INTERVAL_MS   = 16'd1000;

    // Queue count limit and width of the limited count
    localparam int          COUNT_W         = 16;
    localparam logic [15:0] QUEUE_COUNT_MAX = 16'd255;

    // Frame gap thresholds, ms
    localparam logic [31:0] GAP_FAST_MS     = 32'd50;
    localparam logic [31:0] GAP_MID_MS      = 32'd160;
    localparam logic [31:0] MIN_INTERVAL_MS = 32'd10;

    // Queued-frame thresholds picked from the gap
    localparam logic [15:0] THR_FAST = 16'd3;
    localparam logic [15:0] THR_MID  = 16'd2;
    localparam logic [15:0] THR_SLOW = 16'd1;

endpackage

@@ src/vfrp_decide.sv @@
// ----------------------------------------------------------------------------
// vfrp_decide: release decision for one query
// Lip-sync check against the audio clock, frame gap limiting, queue based
// speed-up and the final delay compare. Pure combinational, mod 2^32 time.
// ----------------------------------------------------------------------------
module vfrp_decide #(
    parameter logic [15:0] QUEUE_COUNT_MAX = vfrp_pkg::QUEUE_COUNT_MAX
) (
    input  vfrp_pkg::vfrp_in_t  item,
    input  vfrp_pkg::vfrp_cfg_t cfg,
    input  logic [31:0]         last_audio_seen,
    input  logic [31:0]         last_paint_time,
    input  logic [31:0]         last_frame_stamp,
    output vfrp_pkg::vfrp_dec_t dec
);

    logic [vfrp_pkg::COUNT_W-1:0] count_ext;
    logic [vfrp_pkg::COUNT_W-1:0] count;
    logic [vfrp_pkg::COUNT_W-1:0] thr;
    logic [vfrp_pkg::COUNT_W-1:0] fast;
    logic [31:0] tol32;
    logic [31:0] max32;
    logic [31:0] minbuf32;
    logic [31:0] d_audio;
    logic [31:0] d_video;
    logic [31:0] d_min;
    logic        audio_ahead;
    logic        sync_hit;
    logic        out_of_tol;
    logic        speed_up;
    logic        hold;
    logic [31:0] buffered;
    logic [31:0] delay;
    logic [31:0] delay_adj;
    logic [31:0] gap_raw;
    logic [31:0] gap;
    logic [31:0] gap_sp;
    logic [31:0] gap_fin;
    logic        add_en;
    logic        timing_ok;

    // Limited queue count
    assign count_ext = {{(vfrp_pkg::COUNT_W-8){1'b0}}, item.queued_count};
    assign count     = (count_ext > QUEUE_COUNT_MAX) ? QUEUE_COUNT_MAX : count_ext;

    assign tol32    = {16'd0, cfg.sync_tolerance_ms};
    assign max32    = {16'd0, cfg.max_interval_ms};
    assign minbuf32 = {16'd0, cfg.min_buffer_ms};

    // Audio/video offset: shorter of the two modular distances
    assign d_audio     = item.audio_clock - item.front_stamp;
    assign d_video     = item.front_stamp - item.audio_clock;
    assign audio_ahead = (d_audio <= d_video);
    assign d_min       = audio_ahead ? d_audio : d_video;

    assign sync_hit   = cfg.sync_enable && (item.audio_clock != last_audio_seen);
    assign out_of_tol = (d_min >= tol32);
    assign speed_up   = sync_hit && out_of_tol && audio_ahead && (d_min != tol32);
    assign hold       = sync_hit && out_of_tol && !audio_ahead && (d_min < max32);

    // Frame gap, zeroed when at or above the interval limit
    assign gap_raw = item.front_stamp - last_frame_stamp;
    assign gap     = (gap_raw >= max32) ? 32'd0 : gap_raw;

    always_comb begin
        if (gap <= vfrp_pkg::GAP_FAST_MS) begin
            thr = vfrp_pkg::THR_FAST;
        end else if (gap <= vfrp_pkg::GAP_MID_MS) begin
            thr = vfrp_pkg::THR_MID;
        end else begin
            thr = vfrp_pkg::THR_SLOW;
        end
    end

    // Extra queued frames pull the release earlier
    assign buffered  = item.newest_stamp - item.front_stamp;
    assign fast      = (count > thr) ? (count - thr) : '0;
    assign add_en    = (buffered > minbuf32) || (count > thr);
    assign delay     = item.now_ms - last_paint_time;
    assign delay_adj = add_en ? (delay + {{(32-vfrp_pkg::COUNT_W){1'b0}}, fast}) : delay;

    // Audio leads: shorten the interval by a quarter, then floor it
    assign gap_sp  = speed_up ? (gap - {2'b00, gap[31:2]}) : gap;
    assign gap_fin = (gap_sp < vfrp_pkg::MIN_INTERVAL_MS) ? vfrp_pkg::MIN_INTERVAL_MS : gap_sp;

    assign timing_ok = (delay_adj >= max32) || (delay_adj >= gap_fin);

    // Priority: empty queue, no stamp, lip-sync hold, timing
    always_comb begin
        dec.audio_update = 1'b0;
        if (count == '0) begin
            dec.release_now = 1'b0;
        end else if (!item.front_has_stamp) begin
            dec.release_now = 1'b1;
        end else begin
            dec.audio_update = sync_hit;
            dec.release_now  = hold ? 1'b0 : timing_ok;
        end
    end

endmodule

@@ src/video_frame_release_pacer.sv @@
// ----------------------------------------------------------------------------
// video_frame_release_pacer: decides when the front queued frame is decoded
//
// Input channel (s_valid/s_ready/s_payload): one transaction per query or
// per painted event. A query returns release_now for the front frame; a
// painted event records the painted stamp and time and returns release 0.
// Every transaction returns exactly one result on the m_ channel, carrying
// the current video clock (last painted stamp).
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no transaction is in flight.
// A transaction passes the input register, then the result register,
// which drives m_valid. Throughput: one transaction per cycle, set by
// the single decision pass, while m_ready does not stall the result.
// Stall: a held result keeps m_payload stable; the input register still
// takes a transaction while the result register is empty or draining, so
// s_ready drops only when both registers are full and m_ready is low.
// Reset: both stages empty, registers at their defaults, history cleared.
// ----------------------------------------------------------------------------
module video_frame_release_pacer #(
    parameter logic [15:0] QUEUE_COUNT_MAX = vfrp_pkg::QUEUE_COUNT_MAX
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vfrp_pkg::vfrp_in_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vfrp_pkg::vfrp_out_t                 m_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vfrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfrp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    vfrp_pkg::vfrp_cfg_t cfg_reg;
    vfrp_pkg::vfrp_in_t  in_item_reg;
    logic                in_valid_reg;
    vfrp_pkg::vfrp_out_t out_item_reg;
    vfrp_pkg::vfrp_out_t out_item_next;
    logic                out_valid_reg;
    logic [31:0]         last_audio_reg;
    logic [31:0]         last_paint_reg;
    logic [31:0]         last_stamp_reg;
    vfrp_pkg::vfrp_dec_t dec;
    logic                advance;
    logic                s_fire;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_enable       <= vfrp_pkg::RST_SYNC_ENABLE;
            cfg_reg.min_buffer_ms     <= vfrp_pkg::RST_MIN_BUFFER_MS;
            cfg_reg.sync_tolerance_ms <= vfrp_pkg::RST_SYNC_TOLERANCE_MS;
            cfg_reg.max_interval_ms   <= vfrp_pkg::RST_MAX_INTERVAL_MS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vfrp_pkg::CFG_SYNC_ENABLE:       cfg_reg.sync_enable       <= cfg_data[0];
                vfrp_pkg::CFG_MIN_BUFFER_MS:     cfg_reg.min_buffer_ms     <= cfg_data;
                vfrp_pkg::CFG_SYNC_TOLERANCE_MS: cfg_reg.sync_tolerance_ms <= cfg_data;
                vfrp_pkg::CFG_MAX_INTERVAL_MS:   cfg_reg.max_interval_ms   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: input stage moves on whenever the result stage is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_payload;
        end
    end

    // Decision for the registered query
    vfrp_decide #(
        .QUEUE_COUNT_MAX (QUEUE_COUNT_MAX)
    ) u_decide (
        .item             (in_item_reg),
        .cfg              (cfg_reg),
        .last_audio_seen  (last_audio_reg),
        .last_paint_time  (last_paint_reg),
        .last_frame_stamp (last_stamp_reg),
        .dec              (dec)
    );

    // Result formation
    always_comb begin
        if (in_item_reg.mode == vfrp_pkg::MODE_PAINTED) begin
            out_item_next.release_now = 1'b0;
            out_item_next.video_clock = in_item_reg.painted_frame_stamp;
        end else begin
            out_item_next.release_now = dec.release_now;
            out_item_next.video_clock = last_stamp_reg;
        end
    end

    // History update, in transaction order as each one leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_audio_reg <= '0;
            last_paint_reg <= '0;
            last_stamp_reg <= '0;
        end else if (advance) begin
            if (in_item_reg.mode == vfrp_pkg::MODE_PAINTED) begin
                last_stamp_reg <= in_item_reg.painted_frame_stamp;
                last_paint_reg <= in_item_reg.painted_time;
            end else if (dec.audio_update) begin
                last_audio_reg <= in_item_reg.audio_clock;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

endmodule

@@ src/vfrp_checker.sv @@
// ----------------------------------------------------------------------------
// vfrp_checker: port-level checks for the video frame release pacer
// Watches the channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module vfrp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input vfrp_pkg::vfrp_in_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input vfrp_pkg::vfrp_out_t m_payload
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // An open receiver never back-pressures the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

    // Empty queue never releases (checked on the path with no stall)
    a_empty_q: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.mode == vfrp_pkg::MODE_QUERY
         && s_payload.queued_count == 8'd0) ##1 m_ready
        |=> m_valid && !m_payload.release_now)
        else $error("release on empty queue");

    // Painted event echoes its stamp as video clock
    a_paint_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.mode == vfrp_pkg::MODE_PAINTED) ##1 m_ready
        |=> m_valid && !m_payload.release_now
            && m_payload.video_clock == $past(s_payload.painted_frame_stamp, 2))
        else $error("painted event result wrong");

endmodule

bind video_frame_release_pacer vfrp_checker u_vfrp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for video_frame_release_pacer
// Drives release queries and painted events with bursty valid/ready traffic
// and a stalling receiver, predicts every result from a local model of the
// pacing rules, and checks each result in order. Runs under several register
// settings, including the extremes of every register.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT  = 5000;  // cycles without any transaction
    localparam int DRAIN_HOLD  = 4;     // two-stage pipe plus margin
    localparam int PHASE_ITEMS = 150;
    localparam int DUE_DEPTH   = 16;    // far above the two results in flight

    // Clock, reset and block ports
    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    vfrp_pkg::vfrp_in_t              s_payload = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    vfrp_pkg::vfrp_out_t             m_payload;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [vfrp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vfrp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the registers and the pacing history
    logic        cfg_sync_en      = vfrp_pkg::RST_SYNC_ENABLE;
    logic [31:0] cfg_min_buffer   = {16'd0, vfrp_pkg::RST_MIN_BUFFER_MS};
    logic [31:0] cfg_tolerance    = {16'd0, vfrp_pkg::RST_SYNC_TOLERANCE_MS};
    logic [31:0] cfg_max_interval = {16'd0, vfrp_pkg::RST_MAX_INTERVAL_MS};
    logic [31:0] hist_audio       = '0;
    logic [31:0] hist_paint_time  = '0;
    logic [31:0] hist_frame_stamp = '0;

    // Results still owed by the block, oldest first (ring buffer)
    vfrp_pkg::vfrp_out_t due_ring [DUE_DEPTH];
    logic [3:0]          due_wr_ptr = '0;
    logic [3:0]          due_rd_ptr = '0;
    int                  due_count  = 0;

    // Stimulus scene: a plausible stream of stamps and clocks
    logic [31:0] scene_stamp;
    logic [31:0] scene_clock;
    logic [31:0] scene_audio;

    int mismatches   = 0;
    int n_items      = 0;
    int n_painted    = 0;
    int n_released   = 0;
    int n_settings   = 0;
    int tx_burst     = 1;
    int rx_run       = 0;
    int rx_style     = 0;

    video_frame_release_pacer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Release decision for one query; updates the audio history
    function automatic logic release_decision(input vfrp_pkg::vfrp_in_t t);
        logic [31:0] cnt, thr, buffered, lag, gap, ahead_a, ahead_v, offset;
        logic        speed;
        cnt   = {24'd0, t.queued_count};
        speed = 1'b0;
        if (cnt > {16'd0, vfrp_pkg::QUEUE_COUNT_MAX})
            cnt = {16'd0, vfrp_pkg::QUEUE_COUNT_MAX};
        if (cnt == 32'd0)
            return 1'b0;
        if (!t.front_has_stamp)
            return 1'b1;

        // lip-sync: only on a change of the audio clock
        if (cfg_sync_en && t.audio_clock != hist_audio) begin
            ahead_a    = t.audio_clock - t.front_stamp;
            ahead_v    = t.front_stamp - t.audio_clock;
            offset     = (ahead_a > ahead_v) ? ahead_v : ahead_a;
            hist_audio = t.audio_clock;
            if (offset >= cfg_tolerance) begin
                if (offset == ahead_a)
                    speed = (offset - cfg_tolerance) != 32'd0;
                else if (offset < cfg_max_interval)
                    return 1'b0;
            end
        end

        buffered = t.newest_stamp - t.front_stamp;
        lag      = t.now_ms - hist_paint_time;
        gap      = t.front_stamp - hist_frame_stamp;
        if (gap >= cfg_max_interval)
            gap = '0;

        if (gap <= vfrp_pkg::GAP_FAST_MS)
            thr = {16'd0, vfrp_pkg::THR_FAST};
        else if (gap <= vfrp_pkg::GAP_MID_MS)
            thr = {16'd0, vfrp_pkg::THR_MID};
        else
            thr = {16'd0, vfrp_pkg::THR_SLOW};

        // extra queued frames pull the release earlier
        if (buffered > cfg_min_buffer || cnt > thr)
            lag = lag + ((cnt > thr) ? cnt - thr : 32'd0);

        if (speed)
            gap = gap - (gap >> 2);
        if (gap < vfrp_pkg::MIN_INTERVAL_MS)
            gap = vfrp_pkg::MIN_INTERVAL_MS;

        return (lag >= cfg_max_interval) || (lag >= gap);
    endfunction

    // Expected result of one transaction
    function automatic vfrp_pkg::vfrp_out_t pace_frame(input vfrp_pkg::vfrp_in_t t);
        vfrp_pkg::vfrp_out_t r;
        if (t.mode == vfrp_pkg::MODE_PAINTED) begin
            hist_frame_stamp = t.painted_frame_stamp;
            hist_paint_time  = t.painted_time;
            r.release_now    = 1'b0;
        end else begin
            r.release_now = release_decision(t);
        end
        r.video_clock = hist_frame_stamp;
        return r;
    endfunction

    function automatic vfrp_pkg::vfrp_in_t make_query(input logic [7:0] cnt,
                                                      input logic has,
                                                      input logic [31:0] front, newest, now,
                                                      input logic [31:0] audio);
        vfrp_pkg::vfrp_in_t t;
        t.mode                = vfrp_pkg::MODE_QUERY;
        t.queued_count        = cnt;
        t.front_has_stamp     = has;
        t.front_stamp         = front;
        t.newest_stamp        = newest;
        t.now_ms              = now;
        t.audio_clock         = audio;
        t.painted_frame_stamp = $urandom;
        t.painted_time        = $urandom;
        return t;
    endfunction

    function automatic vfrp_pkg::vfrp_in_t make_paint(input logic [31:0] stamp,
                                                      input logic [31:0] at);
        vfrp_pkg::vfrp_in_t t;
        t = make_query(8'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom);
        t.mode                = vfrp_pkg::MODE_PAINTED;
        t.painted_frame_stamp = stamp;
        t.painted_time        = at;
        return t;
    endfunction

    // Random transaction: mostly coherent paint/query streams, some noise
    function automatic vfrp_pkg::vfrp_in_t make_item();
        vfrp_pkg::vfrp_in_t t;
        int                 pick;
        t = make_query(8'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom);
        t.mode = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return t;
        if (pick < 32) begin
            scene_stamp = scene_stamp + $urandom_range(0, 220);
            scene_clock = scene_clock + $urandom_range(0, 400);
            if ($urandom_range(0, 49) == 0) begin
                scene_stamp = $urandom;
                scene_clock = $urandom;
            end
            return make_paint(scene_stamp, scene_clock);
        end
        t.mode            = vfrp_pkg::MODE_QUERY;
        t.queued_count    = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 6));
        t.front_has_stamp = ($urandom_range(0, 15) != 0);
        t.front_stamp     = scene_stamp + $urandom_range(0, 400) - $urandom_range(0, 40);
        t.newest_stamp    = t.front_stamp + $urandom_range(0, 300);
        t.now_ms          = scene_clock + $urandom_range(0, 1300);
        case ($urandom_range(0, 3))
            0: ;  // audio clock unchanged
            1: scene_audio = t.front_stamp + $urandom_range(0, 1600);
            2: scene_audio = t.front_stamp - $urandom_range(0, 1600);
            default: scene_audio = $urandom;
        endcase
        t.audio_clock = scene_audio;
        return t;
    endfunction

    // Send one transaction; called at a falling edge, returns at one
    task automatic send_item(input vfrp_pkg::vfrp_in_t t);
        s_payload <= t;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        tx_burst = tx_burst - 1;
        if (tx_burst <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            tx_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
        end
    endtask

    // Wait until every owed result has arrived and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (due_count != 0) @(negedge aclk);
        repeat (DRAIN_HOLD) @(negedge aclk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic apply_config(input logic sync, input logic [15:0] min_buf,
                                input logic [15:0] tol, input logic [15:0] max_int);
        logic [vfrp_pkg::CFG_IDX_W-1:0]  regs [4];
        logic [vfrp_pkg::CFG_DATA_W-1:0] vals [4];
        settle();
        regs[0] = vfrp_pkg::CFG_SYNC_ENABLE;       vals[0] = {15'd0, sync};
        regs[1] = vfrp_pkg::CFG_MIN_BUFFER_MS;     vals[1] = min_buf;
        regs[2] = vfrp_pkg::CFG_SYNC_TOLERANCE_MS; vals[2] = tol;
        regs[3] = vfrp_pkg::CFG_MAX_INTERVAL_MS;   vals[3] = max_int;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Reset defaults, lip-sync off: basic decisions and field extremes
    task automatic test_default_decisions();
        send_item(make_paint(32'd1000, 32'd5000));
        send_item(make_query(8'd0, 1'b1, '1, '1, '1, '1));
        send_item(make_query(8'd255, 1'b0, '1, '1, '1, '1));
        send_item(make_query(8'd1, 1'b1, 32'd1040, 32'd1040, 32'd5000, '0));
        send_item(make_query(8'd1, 1'b1, 32'd1040, 32'd1200, 32'd5030, '0));
        send_item(make_query(8'd5, 1'b1, 32'd1040, 32'd1040, 32'd5036, '0));
        send_item(make_query(8'd1, 1'b1, 32'd1040, 32'd1040, 32'd5040, '0));
        send_item(make_query(8'd255, 1'b1, '1, '0, '1, '1));
        send_item(make_paint('1, '1));
        send_item(make_query(8'd3, 1'b1, '0, '0, 32'd2, '0));
        send_item(make_paint('0, '0));
    endtask

    // Lip-sync: speed-up, unchanged audio, hold, exact tolerance, ties
    task automatic test_lip_sync();
        apply_config(1'b1, vfrp_pkg::RST_MIN_BUFFER_MS, vfrp_pkg::RST_SYNC_TOLERANCE_MS,
                     vfrp_pkg::RST_MAX_INTERVAL_MS);
        send_item(make_paint(32'd1000, 32'd5000));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'd1340));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'd1340));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'd740));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'd1240));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'd1040));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'h8000_0410));
        send_item(make_query(8'd2, 1'b1, 32'd1040, 32'd1100, 32'd5030, 32'hFFFF_FE34));
    endtask

    // Zero max interval: every gap collapses and timing always releases
    task automatic test_zero_interval();
        apply_config(1'b1, 16'd0, 16'd0, 16'd0);
        send_item(make_query(8'd1, 1'b1, 32'd1100, 32'd1100, 32'd5000, 32'd1100));
        send_item(make_query(8'd1, 1'b1, 32'd900, 32'd900, 32'd5000, 32'd2000));
        send_item(make_query(8'd4, 1'b1, '1, '1, 32'd5000, 32'd7));
    endtask

    // Random traffic under fixed corner settings
    task automatic test_register_extremes();
        logic [48:0] corners [6];
        corners[0] = {1'b1, 16'd100, 16'd200, 16'd1000};
        corners[1] = {1'b1, 16'd0, 16'd0, 16'd1};
        corners[2] = {1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        corners[3] = {1'b0, 16'd0, 16'hFFFF, 16'd1};
        corners[4] = {1'b1, 16'd50, 16'd40, 16'd300};
        corners[5] = {1'b0, 16'hFFFF, 16'd0, 16'd0};
        foreach (corners[c]) begin
            apply_config(corners[c][48], corners[c][47:32], corners[c][31:16],
                         corners[c][15:0]);
            repeat (PHASE_ITEMS) send_item(make_item());
        end
    endtask

    // Random traffic under random settings
    task automatic test_random_traffic();
        repeat (6) begin
            apply_config(1'($urandom), 16'($urandom_range(0, 400)),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 500)),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(1, 1500)));
            repeat (PHASE_ITEMS) send_item(make_item());
        end
    endtask

    // Receiver: alternating stretches of always-ready, random, heavy and periodic stalls
    always @(negedge aclk) begin
        if (rx_run == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_run   = $urandom_range(20, 120);
        end
        rx_run = rx_run - 1;
        case (rx_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_run % 5) != 0;
        endcase
    end

    // Predict on every accepted transaction, check every accepted result
    always @(posedge aclk) begin
        vfrp_pkg::vfrp_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vfrp_pkg::CFG_SYNC_ENABLE:       cfg_sync_en      = cfg_data[0];
                    vfrp_pkg::CFG_MIN_BUFFER_MS:     cfg_min_buffer   = {16'd0, cfg_data};
                    vfrp_pkg::CFG_SYNC_TOLERANCE_MS: cfg_tolerance    = {16'd0, cfg_data};
                    vfrp_pkg::CFG_MAX_INTERVAL_MS:   cfg_max_interval = {16'd0, cfg_data};
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                due_ring[due_wr_ptr] = pace_frame(s_payload);
                due_wr_ptr = due_wr_ptr + 4'd1;
                due_count++;
                n_items++;
                if (s_payload.mode == vfrp_pkg::MODE_PAINTED)
                    n_painted++;
            end
            if (m_valid && m_ready) begin
                if (m_payload.release_now)
                    n_released++;
                if (due_count == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result release=%0b video_clock=%h",
                                 $realtime, m_payload.release_now, m_payload.video_clock);
                end else begin
                    want = due_ring[due_rd_ptr];
                    due_rd_ptr = due_rd_ptr + 4'd1;
                    due_count--;
                    if (want.release_now !== m_payload.release_now ||
                        want.video_clock !== m_payload.video_clock) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: release exp %0b got %0b, clock exp %h got %h",
                                     $realtime, want.release_now, m_payload.release_now,
                                     want.video_clock, m_payload.video_clock);
                    end
                end
            end
        end
    end

    // Watchdog: stop if no transaction moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: %0d results still owed", due_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        scene_stamp = $urandom;
        scene_clock = $urandom;
        scene_audio = $urandom;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_decisions();
        test_lip_sync();
        test_zero_interval();
        test_register_extremes();
        test_random_traffic();
        settle();

        $display("Run covered %0d transactions (%0d painted events, %0d releases)",
                 n_items, n_painted, n_released);
        $display("over %0d register settings with bursty input and receiver stalls",
                 n_settings + 1);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d bad results", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
